[design/imm_pkg.sv]
// Shared types and constants for the integer matrix multiplier.
// No dependencies; imported by every module of the block.
package imm_pkg;

   localparam int MAX_DIM_DEFAULT    = 8;
   localparam int ELEM_WIDTH_DEFAULT = 16;

   localparam int CFG_W       = 4;
   localparam int DIM_W       = CFG_W + 1;
   localparam int CSR_IDX_W   = 2;
   localparam int PRODUCT_W   = 35;
   localparam int IDX_W       = 3;
   localparam int RSP_PAD_LSB = PRODUCT_W + 2 * IDX_W;
   localparam int RSP_DATA_W  = ((RSP_PAD_LSB + 7) / 8) * 8;
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROWS_A    = 2'd0,
      CSR_INNER_DIM = 2'd1,
      CSR_COLS_B    = 2'd2
   } csr_index_type;

   // clamped matrix dimensions, each 1..MAX_DIM
   typedef struct packed {
      logic [DIM_W-1:0] rows;
      logic [DIM_W-1:0] inner;
      logic [DIM_W-1:0] cols;
   } dims_type;

endpackage

[design/imm_fifo.sv]
// Small synchronous FIFO between the load front end and the compute back end.
// Uses imm_pkg for the default depth.
module imm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = imm_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             out_valid,
   output logic [WIDTH-1:0] out_data
);
   import imm_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && out_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

[design/imm_front.sv]
// Load front end: counts incoming elements, tags each as an A or B store write
// with its address, and marks the element that completes matrix B. Uses imm_pkg.
module imm_front #(
   parameter int MAX_DIM    = imm_pkg::MAX_DIM_DEFAULT,
   parameter int ELEM_WIDTH = imm_pkg::ELEM_WIDTH_DEFAULT,
   parameter int AW         = 6
) (
   input  logic                       clock,
   input  logic                       reset,
   input  imm_pkg::dims_type          dims,
   input  logic                       load_clear,
   input  logic                       elem_valid,
   input  logic [ELEM_WIDTH-1:0]      elem_data,
   output logic                       elem_ready,
   output logic                       wr_push,
   output logic [ELEM_WIDTH+AW+1:0]   wr_word,
   input  logic                       wr_full
);
   import imm_pkg::*;

   localparam int LC_W = $clog2(2 * MAX_DIM * MAX_DIM + 1);

   logic [LC_W-1:0] load_count_ff;
   logic [LC_W-1:0] load_count_in;
   logic [LC_W-1:0] size_a;
   logic [LC_W-1:0] size_total;
   logic            is_b;
   logic            is_final;
   logic [AW-1:0]   addr;
   logic            take;

   assign size_a     = LC_W'(dims.rows) * LC_W'(dims.inner);
   assign size_total = size_a + LC_W'(dims.inner) * LC_W'(dims.cols);
   assign is_b       = (load_count_ff >= size_a);
   assign is_final   = ((load_count_ff + 1'b1) == size_total);
   assign addr       = is_b ? AW'(load_count_ff - size_a) : AW'(load_count_ff);

   assign elem_ready = !wr_full;
   assign take       = elem_valid && elem_ready;
   assign wr_push    = take;
   // word: data, address, B select, final flag (lowest bit up)
   assign wr_word    = {is_final, is_b, addr, elem_data};

   always_comb begin
      load_count_in = load_count_ff;
      if (take) begin
         load_count_in = is_final ? '0 : load_count_ff + 1'b1;
      end
      if (load_clear) begin
         load_count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff <= '0;
      end else begin
         load_count_ff <= load_count_in;
      end
   end

endmodule

[design/imm_back.sv]
// Compute back end: owns the A and B element memories, drains store writes from
// the queue, then walks i, j, k through a read / multiply / accumulate pipeline.
// Uses imm_pkg for dims_type and result widths.
module imm_back #(
   parameter int MAX_DIM    = imm_pkg::MAX_DIM_DEFAULT,
   parameter int ELEM_WIDTH = imm_pkg::ELEM_WIDTH_DEFAULT,
   parameter int AW         = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   input  imm_pkg::dims_type                 dims,
   input  logic                              wr_valid,
   input  logic [ELEM_WIDTH+AW+1:0]          wr_word,
   output logic                              wr_pop,
   output logic                              res_valid,
   input  logic                              res_ready,
   output logic signed [imm_pkg::PRODUCT_W-1:0] res_product,
   output logic [imm_pkg::IDX_W-1:0]         res_row,
   output logic [imm_pkg::IDX_W-1:0]         res_col,
   output logic                              res_last
);
   import imm_pkg::*;

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int CNT_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

   typedef struct packed {
      logic             first;
      logic             last_k;
      logic             last_all;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } tag_type;

   logic [ELEM_WIDTH-1:0] mem_a [DEPTH];
   logic [ELEM_WIDTH-1:0] mem_b [DEPTH];

   logic [ELEM_WIDTH-1:0] wr_data;
   logic [AW-1:0]         wr_addr;
   logic                  wr_is_b;
   logic                  wr_final;

   logic                  busy_ff;
   logic [CNT_W-1:0]      i_ff, j_ff, k_ff;
   logic [CNT_W-1:0]      i_in, j_in, k_in;
   logic [AW-1:0]         ia_ff, ib_ff, rowbase_ff;
   logic [AW-1:0]         ia_in, ib_in, rowbase_in;
   logic                  busy_in;
   logic                  adv;
   logic                  last_k, last_j, last_i;
   tag_type               tag_issue;

   logic                         s1_valid_ff;
   tag_type                      s1_tag_ff;
   logic signed [ELEM_WIDTH-1:0] rd_a_ff, rd_b_ff;
   logic                         s2_valid_ff;
   tag_type                      s2_tag_ff;
   logic signed [2*ELEM_WIDTH-1:0] mul_ff;
   logic signed [PRODUCT_W-1:0]  acc_ff;
   logic signed [PRODUCT_W-1:0]  acc_in;

   logic                         res_valid_ff;
   logic signed [PRODUCT_W-1:0]  res_product_ff;
   logic [IDX_W-1:0]             res_row_ff, res_col_ff;
   logic                         res_last_ff;

   assign {wr_final, wr_is_b, wr_addr, wr_data} = wr_word;
   assign wr_pop = wr_valid && !busy_ff;
   assign adv    = !res_valid_ff || res_ready;

   assign last_k = (DIM_W'(k_ff) == dims.inner - DIM_W'(1));
   assign last_j = (DIM_W'(j_ff) == dims.cols - DIM_W'(1));
   assign last_i = (DIM_W'(i_ff) == dims.rows - DIM_W'(1));

   assign tag_issue = '{first:    (k_ff == '0),
                        last_k:   last_k,
                        last_all: last_k && last_j && last_i,
                        row:      IDX_W'(i_ff),
                        col:      IDX_W'(j_ff)};

   always_comb begin
      busy_in    = busy_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      ia_in      = ia_ff;
      ib_in      = ib_ff;
      rowbase_in = rowbase_ff;
      if (!busy_ff) begin
         if (wr_pop && wr_final) begin
            busy_in    = 1'b1;
            i_in       = '0;
            j_in       = '0;
            k_in       = '0;
            ia_in      = '0;
            ib_in      = '0;
            rowbase_in = '0;
         end
      end else if (adv) begin
         if (!last_k) begin
            k_in  = k_ff + 1'b1;
            ia_in = ia_ff + 1'b1;
            ib_in = ib_ff + AW'(dims.cols);
         end else begin
            k_in = '0;
            if (!last_j) begin
               j_in  = j_ff + 1'b1;
               ia_in = rowbase_ff;
               ib_in = AW'(j_ff) + AW'(1);
            end else begin
               j_in  = '0;
               ib_in = '0;
               if (!last_i) begin
                  i_in       = i_ff + 1'b1;
                  rowbase_in = rowbase_ff + AW'(dims.inner);
                  ia_in      = rowbase_ff + AW'(dims.inner);
               end else begin
                  busy_in = 1'b0;
               end
            end
         end
      end
   end

   assign acc_in = s2_tag_ff.first ? PRODUCT_W'(mul_ff) : acc_ff + PRODUCT_W'(mul_ff);

   always_ff @(posedge clock) begin
      if (wr_pop && !wr_is_b) begin
         mem_a[wr_addr] <= wr_data;
      end
      if (adv) begin
         rd_a_ff <= mem_a[ia_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_pop && wr_is_b) begin
         mem_b[wr_addr] <= wr_data;
      end
      if (adv) begin
         rd_b_ff <= mem_b[ib_ff];
      end
   end

   always_ff @(posedge clock) begin
      i_ff       <= i_in;
      j_ff       <= j_in;
      k_ff       <= k_in;
      ia_ff      <= ia_in;
      ib_ff      <= ib_in;
      rowbase_ff <= rowbase_in;
      if (adv) begin
         s1_tag_ff <= tag_issue;
         s2_tag_ff <= s1_tag_ff;
         mul_ff    <= rd_a_ff * rd_b_ff;
         if (s2_valid_ff) begin
            acc_ff <= acc_in;
            if (s2_tag_ff.last_k) begin
               res_product_ff <= acc_in;
               res_row_ff     <= s2_tag_ff.row;
               res_col_ff     <= s2_tag_ff.col;
               res_last_ff    <= s2_tag_ff.last_all;
            end
         end
      end
      if (reset) begin
         busy_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         if (adv) begin
            s1_valid_ff  <= busy_ff;
            s2_valid_ff  <= s1_valid_ff;
            res_valid_ff <= s2_valid_ff && s2_tag_ff.last_k;
         end
      end
   end

   assign res_valid   = res_valid_ff;
   assign res_product = res_product_ff;
   assign res_row     = res_row_ff;
   assign res_col     = res_col_ff;
   assign res_last    = res_last_ff;

endmodule

[design/integer_matrix_multiply.sv]
// Integer matrix multiplier, streaming in and out.
// Channels: req_* carries one signed element per transfer, first matrix A
// (rows_a x inner_dim) then matrix B (inner_dim x cols_b), both row-major.
// rsp_* returns C = A * B row-major, one element per transfer, with its row
// and column; rsp_tlast marks the final element of C.
// csr_*: write rows_a (0), inner_dim (1), cols_b (2) while idle. A write to
// one of them restarts the load; 0 counts as 1, above MAX_DIM as MAX_DIM.
// Timing: loading takes one element per cycle while the queue has room. The back end
// then runs one multiply-accumulate per cycle unless the result channel stalls,
// rows_a * cols_b * inner_dim in all, set by the single read port of each element
// memory; each result passes through the read, multiply and accumulate registers.
// Results are exact modulo 2^35.
// Reset: dimensions return to 8, the load count to zero, pipeline empties.
// A stalled receiver freezes the compute pipeline; the front end keeps
// taking elements until its 4-entry queue fills, then drops req_tready.
// Depends on imm_pkg, imm_front, imm_fifo, imm_back.
module integer_matrix_multiply #(
   parameter int MAX_DIM    = imm_pkg::MAX_DIM_DEFAULT,
   parameter int ELEM_WIDTH = imm_pkg::ELEM_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((ELEM_WIDTH+7)/8)*8-1:0]     req_tdata,   // element
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [imm_pkg::RSP_DATA_W-1:0]      rsp_tdata,   // product, row, col
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [imm_pkg::CSR_IDX_W-1:0]       csr_addr,
   input  logic [imm_pkg::CFG_W-1:0]           csr_wdata
);
   import imm_pkg::*;

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WORD_W = ELEM_WIDTH + AW + 2;

   logic [CFG_W-1:0] rows_a_ff, inner_dim_ff, cols_b_ff;
   logic             load_clear;
   dims_type         dims;

   logic              wr_push, wr_full, wr_pop, wr_valid;
   logic [WORD_W-1:0] front_word, queue_word;

   logic signed [PRODUCT_W-1:0] res_product;
   logic [IDX_W-1:0]            res_row, res_col;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = DIM_W'(v);
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (int'(v) > MAX_DIM) begin
         r = DIM_W'(MAX_DIM);
      end
      return r;
   endfunction

   assign dims = '{rows:  clamp_dim(rows_a_ff),
                   inner: clamp_dim(inner_dim_ff),
                   cols:  clamp_dim(cols_b_ff)};

   always_comb begin
      load_clear = 1'b0;
      if (csr_we) begin
         unique case (csr_addr) inside
            CSR_ROWS_A, CSR_INNER_DIM, CSR_COLS_B: load_clear = 1'b1;
            default:                               load_clear = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= CFG_W'(8);
         inner_dim_ff <= CFG_W'(8);
         cols_b_ff    <= CFG_W'(8);
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_ROWS_A:    rows_a_ff    <= csr_wdata;
            CSR_INNER_DIM: inner_dim_ff <= csr_wdata;
            CSR_COLS_B:    cols_b_ff    <= csr_wdata;
            default:       ;
         endcase
      end
   end

   imm_front #(
      .MAX_DIM   (MAX_DIM),
      .ELEM_WIDTH(ELEM_WIDTH),
      .AW        (AW)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .dims      (dims),
      .load_clear(load_clear),
      .elem_valid(req_tvalid),
      .elem_data (req_tdata[ELEM_WIDTH-1:0]),
      .elem_ready(req_tready),
      .wr_push   (wr_push),
      .wr_word   (front_word),
      .wr_full   (wr_full)
   );

   imm_fifo #(
      .WIDTH(WORD_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (wr_push),
      .push_data(front_word),
      .full     (wr_full),
      .pop      (wr_pop),
      .out_valid(wr_valid),
      .out_data (queue_word)
   );

   imm_back #(
      .MAX_DIM   (MAX_DIM),
      .ELEM_WIDTH(ELEM_WIDTH),
      .AW        (AW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .dims       (dims),
      .wr_valid   (wr_valid),
      .wr_word    (queue_word),
      .wr_pop     (wr_pop),
      .res_valid  (rsp_tvalid),
      .res_ready  (rsp_tready),
      .res_product(res_product),
      .res_row    (res_row),
      .res_col    (res_col),
      .res_last   (rsp_tlast)
   );

   assign rsp_tdata = {(RSP_DATA_W - RSP_PAD_LSB)'(1'b0),
                       res_col, res_row, res_product};

endmodule

[design/imm_checker.sv]
// Port-level checks on the result channel of integer_matrix_multiply,
// bound to the top level. Uses imm_pkg for the result layout.
module imm_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [imm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tlast
);
   import imm_pkg::*;

   localparam int ROW_LSB = PRODUCT_W;
   localparam int COL_LSB = PRODUCT_W + IDX_W;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:RSP_PAD_LSB] == '0)
      else $error("result padding bits not zero");

   a_restart_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=>
         !rsp_tvalid || (rsp_tdata[ROW_LSB+IDX_W-1:ROW_LSB] == '0 &&
                         rsp_tdata[COL_LSB+IDX_W-1:COL_LSB] == '0))
      else $error("result after the final one is not row 0 col 0");

endmodule

bind integer_matrix_multiply imm_checker u_imm_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tlast (rsp_tlast)
);

[tb/tb_top.sv]
// Self-checking testbench for integer_matrix_multiply: streams A and B elements in,
// predicts C = A * B per completed load and checks each result transfer in order.
// Depends on imm_pkg and the integer_matrix_multiply RTL.
`timescale 1ns / 1ps

module tb_top;
   import imm_pkg::*;

   localparam int ELEM_W        = 16;
   localparam int MAX_DIM       = 8;
   localparam int IDLE_PCT      = 22;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 24;
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int RAND_ITEMS    = 20;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   typedef struct packed {
      logic [PRODUCT_W-1:0] product;
      logic [IDX_W-1:0]     row;
      logic [IDX_W-1:0]     col;
      logic                 last;
   } c_entry_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [ELEM_W-1:0]      req_tdata = '0;       // element
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;            // product, row, col
   logic                   rsp_tlast;
   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_addr = '0;
   logic [CFG_W-1:0]       csr_wdata = '0;

   integer_matrix_multiply dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // predictor state
   logic [CFG_W-1:0]          reg_rows = 4'd8;
   logic [CFG_W-1:0]          reg_inner = 4'd8;
   logic [CFG_W-1:0]          reg_cols = 4'd8;
   logic signed [ELEM_W-1:0]  mat_a [MAX_DIM*MAX_DIM];
   logic signed [ELEM_W-1:0]  mat_b [MAX_DIM*MAX_DIM];
   int unsigned               loaded = 0;

   logic [ELEM_W-1:0] elem_queue [$];
   c_entry_type       c_pending [$];

   bit          steady = 1'b0;
   int          hold_reqs = 0;
   int          hold_seen = 0;
   int          hold_left = 0;
   int          fails = 0;
   int unsigned elems_sent = 0;
   int unsigned rand_items = 0;
   int unsigned products_done = 0;
   int unsigned results_checked = 0;
   int unsigned settings = 0;
   int unsigned cycle_count = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int unsigned eff_dim(logic [CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return 32'(v);
   endfunction

   function automatic int unsigned job_len();
      int unsigned n;
      n = eff_dim(reg_inner);
      return eff_dim(reg_rows) * n + n * eff_dim(reg_cols);
   endfunction

   // store one element; on the last B element, queue all of C
   function automatic void take_element(logic [ELEM_W-1:0] e);
      int unsigned r, n, c;
      longint      acc;
      c_entry_type ent;
      r = eff_dim(reg_rows);
      n = eff_dim(reg_inner);
      c = eff_dim(reg_cols);
      if (loaded < r * n) mat_a[loaded] = e;
      else mat_b[loaded - r * n] = e;
      loaded++;
      elems_sent++;
      if (loaded == r * n + n * c) begin
         loaded = 0;
         products_done++;
         for (int i = 0; i < r; i++) begin
            for (int j = 0; j < c; j++) begin
               acc = 0;
               for (int k = 0; k < n; k++)
                  acc += longint'(mat_a[i*n+k]) * longint'(mat_b[k*c+j]);
               ent.product = acc[PRODUCT_W-1:0];
               ent.row     = i[IDX_W-1:0];
               ent.col     = j[IDX_W-1:0];
               ent.last    = (i == r - 1) && (j == c - 1);
               c_pending.push_back(ent);
            end
         end
      end
   endfunction

   // element driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) take_element(elem_queue.pop_front());
         if (elem_queue.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
            req_tvalid <= 1'b1;
            req_tdata  <= elem_queue[0];
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result back-pressure, with a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_seen != hold_reqs) begin
         hold_seen  <= hold_reqs;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // result monitor
   always @(posedge clock) begin
      c_entry_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (c_pending.size() == 0) begin
            $error("result transfer with nothing expected: product %0d row %0d col %0d",
                   $signed(rsp_tdata[PRODUCT_W-1:0]), rsp_tdata[PRODUCT_W +: IDX_W],
                   rsp_tdata[PRODUCT_W+IDX_W +: IDX_W]);
            fails++;
         end else begin
            want = c_pending.pop_front();
            results_checked++;
            if (rsp_tdata[PRODUCT_W-1:0] !== want.product) begin
               $error("product: expected %0d, got %0d", $signed(want.product),
                      $signed(rsp_tdata[PRODUCT_W-1:0]));
               fails++;
            end
            if (rsp_tdata[PRODUCT_W +: IDX_W] !== want.row) begin
               $error("row: expected %0d, got %0d", want.row, rsp_tdata[PRODUCT_W +: IDX_W]);
               fails++;
            end
            if (rsp_tdata[PRODUCT_W+IDX_W +: IDX_W] !== want.col) begin
               $error("col: expected %0d, got %0d", want.col,
                      rsp_tdata[PRODUCT_W+IDX_W +: IDX_W]);
               fails++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_tlast);
               fails++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      case (idx)
         CSR_ROWS_A:    reg_rows = val;
         CSR_INNER_DIM: reg_inner = val;
         CSR_COLS_B:    reg_cols = val;
         default:       return;
      endcase
      loaded = 0;
   endtask

   task automatic settle();
      while (elem_queue.size() != 0 || c_pending.size() != 0 || req_tvalid)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [ELEM_W-1:0] rand_elem();
      case ($urandom_range(0, 9))
         0:       return 16'h8000;
         1:       return 16'h7fff;
         default: return ELEM_W'($urandom);
      endcase
   endfunction

   function automatic void push_rand(int unsigned n);
      for (int i = 0; i < n; i++) elem_queue.push_back(rand_elem());
      rand_items += n;
   endfunction

   // mostly small dimensions, sometimes large, zero or above range
   function automatic logic [CFG_W-1:0] pick_dim();
      int unsigned sel;
      sel = $urandom_range(0, 19);
      if (sel < 14) return CFG_W'($urandom_range(1, 4));
      if (sel < 16) return CFG_W'($urandom_range(5, 8));
      if (sel == 16) return '0;
      return CFG_W'($urandom_range(9, 15));
   endfunction

   initial begin
      int unsigned jobs;
      int unsigned part;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset dimensions 8x8x8 with extreme operands: largest and most negative sums,
      // streamed with no idling on either side
      steady = 1'b1;
      for (int i = 0; i < 64; i++) elem_queue.push_back(16'h8000);
      for (int i = 0; i < 64; i++) elem_queue.push_back(i[0] ? 16'h7fff : 16'h8000);
      settle();
      steady = 1'b0;
      settings++;

      // 1x1x1
      write_reg(CSR_ROWS_A, 4'd1);
      write_reg(CSR_INNER_DIM, 4'd1);
      write_reg(CSR_COLS_B, 4'd1);
      elem_queue.push_back(16'h8000);
      elem_queue.push_back(16'h8000);
      settle();
      settings++;

      // rows 0 acts as 1, cols 15 as 8; unmapped write mid-load keeps the load
      write_reg(CSR_ROWS_A, 4'd0);
      write_reg(CSR_COLS_B, 4'hf);
      elem_queue.push_back(16'h7fff);
      settle();
      write_reg(CSR_UNMAPPED, 4'h5);
      for (int i = 0; i < 8; i++) elem_queue.push_back(i[0] ? 16'h8000 : 16'h7fff);
      settle();
      settings++;

      // register write during a load drops the partial load
      write_reg(CSR_COLS_B, 4'd1);
      elem_queue.push_back(16'h1234);
      settle();
      write_reg(CSR_INNER_DIM, 4'd2);
      for (int i = 0; i < 4; i++) elem_queue.push_back(rand_elem());
      settle();
      settings++;

      // long result hold-off while jobs keep coming, so the input stalls
      write_reg(CSR_ROWS_A, 4'd2);
      write_reg(CSR_INNER_DIM, 4'd2);
      write_reg(CSR_COLS_B, 4'd2);
      hold_reqs++;
      for (int i = 0; i < 5; i++)
         for (int k = 0; k < 8; k++) elem_queue.push_back(rand_elem());
      settle();
      settings++;

      rand_items = 0;
      while (rand_items < RAND_ITEMS) begin
         write_reg(CSR_ROWS_A, pick_dim());
         write_reg(CSR_INNER_DIM, pick_dim());
         write_reg(CSR_COLS_B, pick_dim());
         settings++;
         steady = (settings == 8);
         jobs = $urandom_range(1, 3);
         for (int j = 0; j < jobs; j++) begin
            if ($urandom_range(0, 5) == 0 && job_len() > 1) begin
               part = $urandom_range(1, job_len() - 1);
               push_rand(part);
               settle();
               if ($urandom_range(0, 1)) begin
                  write_reg(CSR_UNMAPPED, CFG_W'($urandom));
                  push_rand(job_len() - part);
               end else begin
                  write_reg(CSR_COLS_B, reg_cols);
                  push_rand(job_len());
               end
            end else begin
               push_rand(job_len());
            end
            if ($urandom_range(0, 3) == 0) settle();
            if (rand_items >= RAND_ITEMS) break;
         end
         settle();
         steady = 1'b0;
      end

      settle();
      if (c_pending.size() != 0) begin
         $error("%0d expected results never arrived", c_pending.size());
         fails++;
      end
      $display("Covered %0d element transfers, %0d products, %0d result transfers checked,",
               elems_sent, products_done, results_checked);
      $display("%0d dimension settings incl. out-of-range and reset values", settings);
      if (fails == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[integer_matrix_multiply.f]
design/imm_pkg.sv
design/imm_fifo.sv
design/imm_front.sv
design/imm_back.sv
design/integer_matrix_multiply.sv
design/imm_checker.sv
tb/tb_top.sv
